@@ rtl/bbg_pkg.sv @@
// ----------------------------------------------------------------------------
// bbg_pkg
// Shared types and constants of the three-state cell grid stepper:
// operation codes, cell codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package bbg_pkg;

  // Field widths of the item ports
  localparam int OP_W   = 2;
  localparam int IDX_W  = 6;
  localparam int CELL_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Cell codes
  localparam logic [CELL_W-1:0] CELL_OFF    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_FIRING = 2'd1;
  localparam logic [CELL_W-1:0] CELL_DYING  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_UNUSED = 2'd3;

  // Number of firing neighbors that turns an off cell on
  localparam logic [3:0] BIRTH_COUNT = 4'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_STEP,
    ST_OUT
  } state_t;

endpackage

@@ rtl/bbg_row_mem.sv @@
// ----------------------------------------------------------------------------
// bbg_row_mem
// Grid storage, one row of cells per entry. One write and one read port,
// read data registered. A valid bit per row, cleared at reset, makes an
// unwritten row read as all cells off.
// ----------------------------------------------------------------------------
module bbg_row_mem
  import bbg_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  // Store and fetch row data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Track which rows hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
    end
  end

  // Mask rows never written since reset
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

@@ rtl/bbg_row_update.sv @@
// ----------------------------------------------------------------------------
// bbg_row_update
// Next generation of one row from the old row above, the row itself and
// the row below. Columns wrap around at the edges.
// ----------------------------------------------------------------------------
module bbg_row_update
  import bbg_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic [GRID_SIZE*CELL_W-1:0] prev_row,
  input  logic [GRID_SIZE*CELL_W-1:0] cur_row,
  input  logic [GRID_SIZE*CELL_W-1:0] next_row,
  output logic [GRID_SIZE*CELL_W-1:0] new_row
);

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    localparam int CM = (c + GRID_SIZE - 1) % GRID_SIZE;
    localparam int CP = (c + 1) % GRID_SIZE;

    logic [7:0]        fire;
    logic [3:0]        n_fire;
    logic [CELL_W-1:0] old_cell;
    logic [CELL_W-1:0] new_cell;

    // Gather the firing flags of the eight neighbors
    assign fire = {
      prev_row[CM*CELL_W +: CELL_W] == CELL_FIRING,
      prev_row[c*CELL_W  +: CELL_W] == CELL_FIRING,
      prev_row[CP*CELL_W +: CELL_W] == CELL_FIRING,
      cur_row[CM*CELL_W  +: CELL_W] == CELL_FIRING,
      cur_row[CP*CELL_W  +: CELL_W] == CELL_FIRING,
      next_row[CM*CELL_W +: CELL_W] == CELL_FIRING,
      next_row[c*CELL_W  +: CELL_W] == CELL_FIRING,
      next_row[CP*CELL_W +: CELL_W] == CELL_FIRING
    };
    assign n_fire   = 4'($countones(fire));
    assign old_cell = cur_row[c*CELL_W +: CELL_W];

    // Dying goes off, firing goes dying, off fires on exactly two
    always_comb begin
      unique case (old_cell)
        CELL_DYING:  new_cell = CELL_OFF;
        CELL_FIRING: new_cell = CELL_DYING;
        default:     new_cell = (n_fire == BIRTH_COUNT) ? CELL_FIRING : CELL_OFF;
      endcase
    end

    assign new_row[c*CELL_W +: CELL_W] = new_cell;
  end

endmodule

@@ rtl/brians_brain_generation_step.sv @@
// ----------------------------------------------------------------------------
// brians_brain_generation_step
// Square torus of three-state cells (off, firing, dying) with single-cell
// write and read and a whole-grid generation step.
//
//   channel | direction | ports                                  | handshake
//   in      | input     | in_op, in_row, in_col, in_cell_value   | in_valid/in_ready
//   out     | output    | out_read_value, out_done_op            | out_valid/out_ready
//
// Sequencing: write and read go through the fetch and modify states to the result;
// a step makes one row memory read per cycle through a three-row window.
// Out-of-range and unused operations go straight to the result.
// Reset: per-row valid bits clear the grid at once; no clearing pass.
// Stalls: the result sits in an output register; a new item is accepted
// while it waits, and that item finishes once the register is free.
// ----------------------------------------------------------------------------
module brians_brain_generation_step
  import bbg_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [CELL_W-1:0] in_cell_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] out_read_value,
  output logic [OP_W-1:0]   out_done_op
);

  localparam int RW   = $clog2(GRID_SIZE);
  localparam int LW   = GRID_SIZE * CELL_W;
  localparam int IW   = (RW > IDX_W) ? RW : IDX_W;
  localparam int CNTW = $clog2(GRID_SIZE + 4);

  localparam logic [CNTW-1:0] CNT_SAVE_ROW0 = CNTW'(2);
  localparam logic [CNTW-1:0] CNT_FIRST_WR  = CNTW'(4);
  localparam logic [CNTW-1:0] CNT_LAST_RD   = CNTW'(GRID_SIZE);
  localparam logic [CNTW-1:0] CNT_LAST_MEM  = CNTW'(GRID_SIZE + 1);
  localparam logic [CNTW-1:0] CNT_LAST_SH   = CNTW'(GRID_SIZE + 2);
  localparam logic [CNTW-1:0] CNT_LAST      = CNTW'(GRID_SIZE + 3);
  localparam logic [RW-1:0]   ROW_LAST      = RW'(GRID_SIZE - 1);

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [RW-1:0]     col_r, col_nxt;
  logic [CELL_W-1:0] val_r, val_nxt;
  logic [CELL_W-1:0] rv_r, rv_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_rv_r, out_rv_nxt;
  logic [OP_W-1:0]   out_op_r, out_op_nxt;

  logic [LW-1:0]     win0_r, win1_r, win2_r, row0_r;
  logic [LW-1:0]     new_row;
  logic [LW-1:0]     patched_row;
  logic              win_shift;

  logic [IW:0]       row_ext, col_ext;
  logic              idx_in_grid;
  logic [CNTW-1:0]   cnt_m1, cnt_m4;

  logic              mem_wr_en, mem_rd_en;
  logic [RW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [LW-1:0]     mem_wr_data, mem_rd_data;

  // Row storage
  bbg_row_mem #(
    .DEPTH (GRID_SIZE),
    .WIDTH (LW),
    .AW    (RW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Next generation of the center row of the window
  bbg_row_update #(
    .GRID_SIZE (GRID_SIZE)
  ) u_update (
    .prev_row (win0_r),
    .cur_row  (win1_r),
    .next_row (win2_r),
    .new_row  (new_row)
  );

  // Range check of the cell index
  assign row_ext     = (IW + 1)'(in_row);
  assign col_ext     = (IW + 1)'(in_col);
  assign idx_in_grid = (row_ext < (IW + 1)'(GRID_SIZE)) &&
                       (col_ext < (IW + 1)'(GRID_SIZE));

  assign cnt_m1 = cnt_r - CNTW'(1);
  assign cnt_m4 = cnt_r - CNT_FIRST_WR;

  // Replace one cell in the fetched row
  always_comb begin
    patched_row = mem_rd_data;
    patched_row[col_r*CELL_W +: CELL_W] = (val_r == CELL_UNUSED) ? CELL_OFF : val_r;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_done_op    = out_op_r;

  // Sequencer: next state, memory controls and result register
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    rv_nxt        = rv_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rv_nxt    = out_rv_r;
    out_op_nxt    = out_op_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = row_r;
    mem_wr_data   = patched_row;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = row_r;
    win_shift     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          row_nxt = row_ext[RW-1:0];
          col_nxt = col_ext[RW-1:0];
          val_nxt = in_cell_value;
          rv_nxt  = CELL_OFF;
          cnt_nxt = '0;
          if (in_op == OP_STEP) begin
            state_nxt = ST_STEP;
          end else if ((in_op == OP_WRITE || in_op == OP_READ) && idx_in_grid) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      ST_FETCH: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_MODIFY;
      end

      ST_MODIFY: begin
        if (op_r == OP_WRITE) begin
          mem_wr_en = 1'b1;
        end else begin
          rv_nxt = mem_rd_data[col_r*CELL_W +: CELL_W];
        end
        state_nxt = ST_OUT;
      end

      ST_STEP: begin
        // Read order: last row, then rows 0 to last
        mem_rd_en   = (cnt_r <= CNT_LAST_RD);
        mem_rd_addr = (cnt_r == '0) ? ROW_LAST : cnt_m1[RW-1:0];
        win_shift   = (cnt_r != '0) && (cnt_r <= CNT_LAST_SH);
        // Write back the row centered in the window
        mem_wr_en   = (cnt_r >= CNT_FIRST_WR);
        mem_wr_addr = cnt_m4[RW-1:0];
        mem_wr_data = new_row;
        cnt_nxt     = cnt_r + CNTW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = rv_r;
          out_op_nxt    = op_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    val_r    <= val_nxt;
    rv_r     <= rv_nxt;
    out_rv_r <= out_rv_nxt;
    out_op_r <= out_op_nxt;
  end

  // Advance the three-row window; keep the old row 0 for the wrap at the end
  always_ff @(posedge clk) begin
    if (win_shift) begin
      win0_r <= win1_r;
      win1_r <= win2_r;
      win2_r <= (cnt_r <= CNT_LAST_MEM) ? mem_rd_data : row0_r;
    end
    if (state_r == ST_STEP && cnt_r == CNT_SAVE_ROW0) begin
      row0_r <= mem_rd_data;
    end
  end

  // Checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_wr_en)
    else $error("grid written while idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
    else $error("row read and written in the same cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> cnt_r <= CNT_LAST)
    else $error("step counter past last row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted item left no work");

endmodule

@@ tb/brians_brain_generation_step_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brians_brain_generation_step_tb
// Self-checking bench for the three-state cell grid stepper. A directed
// table covers reset contents, grid corners, the unused cell and operation
// codes, and wrapped neighbors across steps. Random episodes then seed small
// windows of the torus, advance them a few generations and read them back.
// Every result is compared with a behavioral grid copy or a directed typed value.
// ----------------------------------------------------------------------------
module brians_brain_generation_step_tb;
  import bbg_pkg::*;

  localparam int GRID        = 64;
  localparam int ITEM_TOTAL  = 1300;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_AT     = 400;
  localparam int DRAIN_AT    = 800;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] read_value;
    logic [OP_W-1:0]   done_op;
  } result_t;

  // One directed row: item fields, plus a typed expectation where obvious
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [CELL_W-1:0] value;
    logic              typed;
    logic [CELL_W-1:0] typed_rv;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [CELL_W-1:0] in_cell_value;
  logic              out_valid;
  logic              out_ready;
  logic [CELL_W-1:0] out_read_value;
  logic [OP_W-1:0]   out_done_op;

  // Model of the grid and the results still owed by the block
  logic [CELL_W-1:0] grid_state [GRID][GRID];
  logic [CELL_W-1:0] grid_prev  [GRID][GRID];
  result_t           pending_results [$];

  int  item_count;
  int  mismatch_count;
  bit  idle_enable;
  bit  long_hold_req;
  bit  drain_req;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_READ,   6'd0,  6'd0,  CELL_OFF,    1'b1, CELL_OFF},
    '{OP_READ,   6'd63, 6'd63, CELL_OFF,    1'b1, CELL_OFF},
    '{OP_WRITE,  6'd0,  6'd0,  CELL_FIRING, 1'b1, CELL_OFF},
    '{OP_READ,   6'd0,  6'd0,  CELL_OFF,    1'b1, CELL_FIRING},
    '{OP_WRITE,  6'd63, 6'd63, CELL_DYING,  1'b1, CELL_OFF},
    '{OP_READ,   6'd63, 6'd63, CELL_OFF,    1'b1, CELL_DYING},
    '{OP_WRITE,  6'd0,  6'd1,  CELL_UNUSED, 1'b1, CELL_OFF},
    '{OP_READ,   6'd0,  6'd1,  CELL_OFF,    1'b1, CELL_OFF},
    '{OP_UNUSED, 6'd63, 6'd63, CELL_UNUSED, 1'b1, CELL_OFF},
    '{OP_WRITE,  6'd1,  6'd63, CELL_FIRING, 1'b1, CELL_OFF},
    '{OP_WRITE,  6'd42, 6'd21, CELL_OFF,    1'b1, CELL_OFF},
    '{OP_READ,   6'd42, 6'd21, CELL_OFF,    1'b1, CELL_OFF},
    '{OP_STEP,   6'd0,  6'd0,  CELL_OFF,    1'b1, CELL_OFF},
    '{OP_READ,   6'd0,  6'd0,  CELL_OFF,    1'b0, CELL_OFF},
    '{OP_READ,   6'd63, 6'd63, CELL_OFF,    1'b0, CELL_OFF},
    '{OP_READ,   6'd0,  6'd63, CELL_OFF,    1'b0, CELL_OFF},
    '{OP_READ,   6'd1,  6'd0,  CELL_OFF,    1'b0, CELL_OFF},
    '{OP_READ,   6'd1,  6'd63, CELL_OFF,    1'b0, CELL_OFF},
    '{OP_STEP,   6'd21, 6'd42, CELL_DYING,  1'b1, CELL_OFF},
    '{OP_READ,   6'd0,  6'd63, CELL_OFF,    1'b0, CELL_OFF},
    '{OP_READ,   6'd1,  6'd0,  CELL_OFF,    1'b0, CELL_OFF},
    '{OP_STEP,   6'd63, 6'd0,  CELL_FIRING, 1'b0, CELL_OFF},
    '{OP_READ,   6'd0,  6'd63, CELL_OFF,    1'b0, CELL_OFF},
    '{OP_UNUSED, 6'd21, 6'd42, CELL_FIRING, 1'b1, CELL_OFF},
    '{OP_WRITE,  6'd21, 6'd42, CELL_FIRING, 1'b1, CELL_OFF}
  };

  brians_brain_generation_step #(
    .GRID_SIZE(GRID)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_done_op   (out_done_op)
  );

  // Advance the whole torus one generation from a snapshot of the old grid
  function automatic void advance_generation();
    int n;
    grid_prev = grid_state;
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        if (grid_prev[r][c] == CELL_DYING) begin
          grid_state[r][c] = CELL_OFF;
        end else if (grid_prev[r][c] == CELL_FIRING) begin
          grid_state[r][c] = CELL_DYING;
        end else begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if ((dr != 0 || dc != 0) &&
                  grid_prev[(r + dr + GRID) % GRID][(c + dc + GRID) % GRID] == CELL_FIRING)
                n++;
            end
          end
          grid_state[r][c] = (n == int'(BIRTH_COUNT)) ? CELL_FIRING : CELL_OFF;
        end
      end
    end
  endfunction

  // Apply one item to the grid copy and return the result it must produce
  function automatic result_t apply_grid_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                            logic [IDX_W-1:0] col, logic [CELL_W-1:0] value);
    result_t res;
    bit      in_grid;
    in_grid        = (int'(row) < GRID) && (int'(col) < GRID);
    res.read_value = CELL_OFF;
    res.done_op    = op;
    case (op)
      OP_WRITE: begin
        if (in_grid)
          grid_state[row][col] = (value == CELL_UNUSED) ? CELL_OFF : value;
      end
      OP_STEP: begin
        advance_generation();
      end
      OP_READ: begin
        if (in_grid)
          res.read_value = grid_state[row][col];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [CELL_W-1:0] value,
                           bit typed = 1'b0, logic [CELL_W-1:0] typed_rv = CELL_OFF);
    result_t res;
    if (drain_req) begin
      drain_req = 1'b0;
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending_results.size() != 0)
        @(negedge clk);
      @(negedge clk);
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_row        <= row;
    in_col        <= col;
    in_cell_value <= value;
    do @(posedge clk); while (!in_ready);
    res = apply_grid_op(op, row, col, value);
    if (typed)
      res.read_value = typed_rv;
    pending_results.push_back(res);
    item_count++;
    if (item_count == HOLD_AT)
      long_hold_req = 1'b1;
    if (item_count == DRAIN_AT)
      drain_req = 1'b1;
    if (item_count >= ITEM_TOTAL - QUIET_ITEMS)
      idle_enable = 1'b0;
    @(negedge clk);
  endtask

  // Pick a random cell code, mostly firing so that windows come alive
  function automatic logic [CELL_W-1:0] pick_seed_value();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return CELL_FIRING;
    if (roll < 17) return CELL_DYING;
    if (roll < 19) return CELL_OFF;
    return CELL_UNUSED;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus: reset, directed rows, then random window episodes
  initial begin
    logic [IDX_W-1:0] base_r;
    logic [IDX_W-1:0] base_c;
    int               span;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_WRITE;
    in_row        = '0;
    in_col        = '0;
    in_cell_value = CELL_OFF;
    item_count    = 0;
    idle_enable   = 1'b1;
    long_hold_req = 1'b0;
    drain_req     = 1'b0;
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++)
        grid_state[r][c] = CELL_OFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].value,
                dir_rows[i].typed, dir_rows[i].typed_rv);

    while (item_count < ITEM_TOTAL) begin
      base_r = IDX_W'($urandom_range(0, 63));
      base_c = IDX_W'($urandom_range(0, 63));
      span   = $urandom_range(3, 8);
      // seed the window, wrapping past the grid edges
      repeat ($urandom_range(3, 12))
        send_item(OP_WRITE, base_r + IDX_W'($urandom_range(0, span - 1)),
                  base_c + IDX_W'($urandom_range(0, span - 1)), pick_seed_value());
      // advance a few generations, reading around the window after each
      repeat ($urandom_range(1, 4)) begin
        send_item(OP_STEP, IDX_W'($urandom), IDX_W'($urandom), CELL_W'($urandom));
        repeat ($urandom_range(1, 6))
          send_item(OP_READ, base_r + IDX_W'($urandom_range(0, span + 1)) - 1'b1,
                    base_c + IDX_W'($urandom_range(0, span + 1)) - 1'b1, CELL_W'($urandom));
      end
      // noise: any code, any position
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3))
          send_item(OP_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), CELL_W'($urandom));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (GRID + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, none near the end
  initial begin
    int hold_cnt;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
          @(negedge clk);
        long_hold_req = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: read_value=%0d done_op=%0d",
                   out_read_value, out_done_op);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_done_op !== want.done_op) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected read_value=%0d done_op=%0d, got %0d/%0d",
                     want.read_value, want.done_op, out_read_value, out_done_op);
        end
      end
    end
  end

  // Give up well past the slowest correct run
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
